/* hw/rtl/tsn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsn_pkg
// shared types, register indexes and helper functions of the selector
// narrowing unit
// ----------------------------------------------------------------------------
package tsn_pkg;

	localparam logic [2:0] REG_LOCAL_ADDR_HI  = 3'd0;
	localparam logic [2:0] REG_LOCAL_ADDR_LO  = 3'd1;
	localparam logic [2:0] REG_LOCAL_PREFIX   = 3'd2;
	localparam logic [2:0] REG_LOCAL_PORT     = 3'd3;
	localparam logic [2:0] REG_LOCAL_PROTO    = 3'd4;
	localparam logic [2:0] REG_FROM_INITIATOR = 3'd5;
	localparam logic [2:0] REG_IPV6_MODE      = 3'd6;

	localparam logic [15:0] PORT_ALL = 16'hFFFF;
	localparam logic [7:0]  WIDTH_V6 = 8'd128;
	localparam logic [7:0]  WIDTH_V4 = 8'd32;

	typedef struct packed {
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [7:0]  prefix;
		logic [15:0] port;
		logic [7:0]  proto;
		logic        initiator;
		logic        ipv6;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{addr_hi: 64'd0, addr_lo: 64'd0, prefix: 8'd0,
		port: 16'd0, proto: 8'd0, initiator: 1'b0, ipv6: 1'b1};

	typedef struct packed {
		logic         first;
		logic         last;
		logic         init;
		logic         ipv6;
		logic         ok;
		logic [127:0] peer_s;
		logic [127:0] peer_e;
		logic [15:0]  peer_ps;
		logic [15:0]  peer_pe;
		logic [7:0]   peer_proto;
		logic [127:0] r_s;
		logic [127:0] r_e;
		logic [15:0]  r_ps;
		logic [15:0]  r_pe;
		logic [7:0]   r_proto;
		logic [7:0]   prefix;
		logic [127:0] r_diff;
		logic [127:0] n_e;
		logic [15:0]  n_ps;
		logic [15:0]  n_pe;
		logic [127:0] n_diff;
		logic [15:0]  n_pdiff;
	} item_t;

	function automatic logic [127:0] addr_mask(input logic ipv6);
		return ipv6 ? {128{1'b1}} : {96'd0, 32'hFFFF_FFFF};
	endfunction

	function automatic logic [7:0] addr_width(input logic ipv6);
		return ipv6 ? WIDTH_V6 : WIDTH_V4;
	endfunction

	function automatic logic [127:0] low_ones(input logic [7:0] k);
		logic [127:0] m;
		for (int i = 0; i < 128; i++)
			m[i] = (8'(i) < k);
		return m;
	endfunction

	// trailing zeros of a masked address, capped at the width
	function automatic logic [7:0] tz128(input logic [127:0] v, input logic [7:0] w);
		logic [7:0] n;
		n = w;
		for (int i = 127; i >= 0; i--)
			if (v[i])
				n = 8'(i);
		return n;
	endfunction

	function automatic logic [15:0] single_port(input logic [15:0] ps, input logic [15:0] pe);
		return (ps != 16'd0 || pe != PORT_ALL) ? ps : 16'd0;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/traffic_selector_narrowing_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// traffic_selector_narrowing_unit
// narrows a stream of peer traffic selector ranges against the local
// selector and reports the chosen subnet, port and protocol per payload
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        input      in_valid/in_ready     start/end address, ports, proto, framing
// out       output     out_valid/out_ready   selected subnet, port, proto, flags
// cfg       input      cfg_we                cfg_idx, cfg_wdata
//
// one selector per cycle while no earlier result waits on out_ready; a result is
// registered after the transfer of its last selector (stage 1 loads at the
// transfer, then stage 2, the queue and the back state update into the output register)
// while a result waits, stage 1, stage 2 and the two-entry queue hold items
// reset clears the control state and the tsn_back payload state; ipv6_mode resets to 1
// ----------------------------------------------------------------------------
module traffic_selector_narrowing_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [63:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] start_hi,
	input  wire logic [63:0] start_lo,
	input  wire logic [63:0] end_hi,
	input  wire logic [63:0] end_lo,
	input  wire logic [15:0] port_start,
	input  wire logic [15:0] port_end,
	input  wire logic [7:0]  proto,
	input  wire logic        first_item,
	input  wire logic        last_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      sel_addr_hi,
	output logic [63:0]      sel_addr_lo,
	output logic [7:0]       sel_prefix,
	output logic [15:0]      sel_port,
	output logic [7:0]       sel_proto,
	output logic             accepted,
	output logic             narrowed
);
	import tsn_pkg::*;

	cfg_t  cfg_q;
	item_t f_item, b_item;
	logic  f_valid, f_ready, b_valid, b_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LOCAL_ADDR_HI:  cfg_q.addr_hi   <= cfg_wdata;
				REG_LOCAL_ADDR_LO:  cfg_q.addr_lo   <= cfg_wdata;
				REG_LOCAL_PREFIX:   cfg_q.prefix    <= cfg_wdata[7:0];
				REG_LOCAL_PORT:     cfg_q.port      <= cfg_wdata[15:0];
				REG_LOCAL_PROTO:    cfg_q.proto     <= cfg_wdata[7:0];
				REG_FROM_INITIATOR: cfg_q.initiator <= cfg_wdata[0];
				REG_IPV6_MODE:      cfg_q.ipv6      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	tsn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_hi   (start_hi),
		.start_lo   (start_lo),
		.end_hi     (end_hi),
		.end_lo     (end_lo),
		.port_start (port_start),
		.port_end   (port_end),
		.proto      (proto),
		.first_item (first_item),
		.last_item  (last_item),
		.item_valid (f_valid),
		.item       (f_item),
		.item_ready (f_ready)
	);

	tsn_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_item   (b_item)
	);

	tsn_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (b_valid),
		.item_ready  (b_ready),
		.item        (b_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sel_addr_hi (sel_addr_hi),
		.sel_addr_lo (sel_addr_lo),
		.sel_prefix  (sel_prefix),
		.sel_port    (sel_port),
		.sel_proto   (sel_proto),
		.accepted    (accepted),
		.narrowed    (narrowed)
	);

endmodule
`default_nettype wire

/* hw/rtl/tsn_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsn_front
// two-stage front: intersects each peer range with the local selector, then
// rounds it to a subnet and precomputes the span sizes
// ----------------------------------------------------------------------------
module tsn_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  tsn_pkg::cfg_t       cfg,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [63:0]    start_hi,
	input  wire logic [63:0]    start_lo,
	input  wire logic [63:0]    end_hi,
	input  wire logic [63:0]    end_lo,
	input  wire logic [15:0]    port_start,
	input  wire logic [15:0]    port_end,
	input  wire logic [7:0]     proto,
	input  wire logic           first_item,
	input  wire logic           last_item,
	output logic                item_valid,
	output tsn_pkg::item_t      item,
	input  wire logic           item_ready
);
	import tsn_pkg::*;

	typedef struct packed {
		logic         first;
		logic         last;
		logic         init;
		logic         ipv6;
		logic         ok;
		logic [127:0] peer_s;
		logic [127:0] peer_e;
		logic [15:0]  peer_ps;
		logic [15:0]  peer_pe;
		logic [7:0]   peer_proto;
		logic [127:0] r_s;
		logic [127:0] r_e;
		logic [15:0]  r_ps;
		logic [15:0]  r_pe;
		logic [7:0]   r_proto;
	} s1_t;

	logic   v1_q, v2_q, en1, en2;
	s1_t    s1_d, data_s1;
	item_t  s2_d, data_s2;

	logic [127:0] wm, la, hm, ls, le;
	logic [7:0]   w, p;
	logic [15:0]  lps, lpe;
	logic         ok_p;

	assign en2      = !v2_q || item_ready;
	assign en1      = !v1_q || en2;
	assign in_ready = en1;

	// stage 1: local span and intersection
	always_comb begin
		wm = addr_mask(cfg.ipv6);
		w  = addr_width(cfg.ipv6);
		p  = (cfg.prefix > w) ? w : cfg.prefix;
		hm = low_ones(w - p);
		la = {cfg.addr_hi, cfg.addr_lo} & wm;
		ls = la & ~hm;
		le = la | hm;
		lps = cfg.port;
		lpe = (cfg.port != 16'd0) ? cfg.port : PORT_ALL;

		s1_d.first      = first_item;
		s1_d.last       = last_item;
		s1_d.init       = cfg.initiator;
		s1_d.ipv6       = cfg.ipv6;
		s1_d.peer_s     = {start_hi, start_lo} & wm;
		s1_d.peer_e     = {end_hi, end_lo} & wm;
		s1_d.peer_ps    = port_start;
		s1_d.peer_pe    = port_end;
		s1_d.peer_proto = proto;

		ok_p = 1'b1;
		if (cfg.proto == 8'd0) begin
			s1_d.r_proto = proto;
		end else if (proto == 8'd0 || proto == cfg.proto) begin
			s1_d.r_proto = cfg.proto;
		end else begin
			s1_d.r_proto = cfg.proto;
			ok_p = 1'b0;
		end
		s1_d.r_s  = (ls < s1_d.peer_s) ? s1_d.peer_s : ls;
		s1_d.r_e  = (le < s1_d.peer_e) ? le : s1_d.peer_e;
		s1_d.r_ps = (lps > port_start) ? lps : port_start;
		s1_d.r_pe = (lpe < port_end) ? lpe : port_end;
		s1_d.ok   = ok_p && !(s1_d.r_e < s1_d.r_s) && (s1_d.r_ps <= s1_d.r_pe);
	end

	// stage 2: subnet rounding and span sizes
	logic [7:0]   k, w2;
	logic [127:0] hm2, wm2;
	logic [15:0]  sp;

	always_comb begin
		w2  = addr_width(data_s1.ipv6);
		wm2 = addr_mask(data_s1.ipv6);
		k   = tz128(data_s1.r_s, w2);
		if (tz128(~data_s1.r_e & wm2, w2) < k)
			k = tz128(~data_s1.r_e & wm2, w2);
		hm2 = low_ones(k);
		sp  = single_port(data_s1.r_ps, data_s1.r_pe);

		s2_d.first      = data_s1.first;
		s2_d.last       = data_s1.last;
		s2_d.init       = data_s1.init;
		s2_d.ipv6       = data_s1.ipv6;
		s2_d.ok         = data_s1.ok;
		s2_d.peer_s     = data_s1.peer_s;
		s2_d.peer_e     = data_s1.peer_e;
		s2_d.peer_ps    = data_s1.peer_ps;
		s2_d.peer_pe    = data_s1.peer_pe;
		s2_d.peer_proto = data_s1.peer_proto;
		s2_d.r_s        = data_s1.r_s;
		s2_d.r_e        = data_s1.r_e;
		s2_d.r_ps       = data_s1.r_ps;
		s2_d.r_pe       = data_s1.r_pe;
		s2_d.r_proto    = data_s1.r_proto;
		s2_d.prefix     = w2 - k;
		s2_d.r_diff     = data_s1.r_e - data_s1.r_s;
		s2_d.n_e        = data_s1.r_s | hm2;
		s2_d.n_ps       = sp;
		s2_d.n_pe       = (sp != 16'd0) ? sp : PORT_ALL;
		s2_d.n_diff     = hm2;
		s2_d.n_pdiff    = (sp != 16'd0) ? 16'd0 : PORT_ALL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (en1)
				v1_q <= in_valid;
			if (en2)
				v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid)
			data_s1 <= s1_d;
		if (en2 && v1_q)
			data_s2 <= s2_d;
	end

	assign item_valid = v2_q;
	assign item       = data_s2;

endmodule
`default_nettype wire

/* hw/rtl/tsn_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsn_fifo
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module tsn_fifo (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push_valid,
	output logic            push_ready,
	input  tsn_pkg::item_t  push_item,
	output logic            pop_valid,
	input  wire logic       pop_ready,
	output tsn_pkg::item_t  pop_item
);
	import tsn_pkg::*;

	item_t      mem [2];
	logic       wptr_q, rptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wptr_q <= ~wptr_q;
			if (pop)
				rptr_q <= ~rptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wptr_q] <= push_item;
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("queue count overflow");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("queue push lost");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> wptr_q == rptr_q)
		else $error("queue pointers out of step");

endmodule
`default_nettype wire

/* hw/rtl/tsn_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsn_back
// payload state: keeps the first range and the best candidate, and emits
// the selection on the last item
// ----------------------------------------------------------------------------
module tsn_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  tsn_pkg::item_t   item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      sel_addr_hi,
	output logic [63:0]      sel_addr_lo,
	output logic [7:0]       sel_prefix,
	output logic [15:0]      sel_port,
	output logic [7:0]       sel_proto,
	output logic             accepted,
	output logic             narrowed
);
	import tsn_pkg::*;

	logic         open_q, no_extra_q, failed_q, narrowed_q;
	logic [127:0] first_s_q, first_e_q, best_s_q, best_e_q, best_diff_q;
	logic [15:0]  first_ps_q, first_pe_q, best_ps_q, best_pe_q;
	logic [7:0]   chosen_q, best_proto_q;

	logic         open_d, no_extra_d, failed_d, narrowed_d;
	logic [127:0] first_s_d, first_e_d, best_s_d, best_e_d, best_diff_d;
	logic [15:0]  first_ps_d, first_pe_d, best_ps_d, best_pe_d;
	logic [7:0]   chosen_d, best_proto_d;

	logic pop, is_first, cand, better, replace;

	logic [127:0] om, sel_s;
	logic [7:0]   ow, hk, hz, held_prefix;

	assign item_ready = !item.last || !out_valid || out_ready;
	assign pop        = item_valid && item_ready;
	assign is_first   = item.first || !open_q;

	assign cand = !failed_q && item.init && item.peer_proto == chosen_q && item.ok &&
		(item.r_proto == 8'd0 || item.r_proto == chosen_q) &&
		!(first_s_q < item.r_s) && !(item.n_e < first_e_q) &&
		item.n_ps <= first_ps_q && item.n_pe >= first_pe_q;
	assign better = (best_diff_q < item.n_diff) || (best_diff_q == item.n_diff &&
		item.n_pdiff > (best_pe_q - best_ps_q));
	assign replace = is_first || (cand && better);

	// prefix of the held best range under the current address width
	always_comb begin
		ow = addr_width(item.ipv6);
		om = addr_mask(item.ipv6);
		hk = tz128(best_s_q & om, ow);
		hz = tz128(~best_e_q & om, ow);
		if (hz < hk)
			hk = hz;
		held_prefix = ow - hk;
	end

	always_comb begin
		open_d        = open_q;
		no_extra_d    = no_extra_q;
		failed_d      = failed_q;
		narrowed_d    = narrowed_q;
		first_s_d     = first_s_q;
		first_e_d     = first_e_q;
		first_ps_d    = first_ps_q;
		first_pe_d    = first_pe_q;
		chosen_d      = chosen_q;
		best_s_d      = best_s_q;
		best_e_d      = best_e_q;
		best_ps_d     = best_ps_q;
		best_pe_d     = best_pe_q;
		best_proto_d  = best_proto_q;
		best_diff_d   = best_diff_q;
		if (is_first) begin
			open_d     = 1'b1;
			no_extra_d = 1'b1;
			narrowed_d = 1'b0;
			failed_d   = !item.ok;
			first_s_d  = item.peer_s;
			first_e_d  = item.peer_e;
			first_ps_d = item.peer_ps;
			first_pe_d = item.peer_pe;
			chosen_d   = item.peer_proto;
			if (item.ok) begin
				best_s_d      = item.r_s;
				best_e_d      = item.r_e;
				best_ps_d     = item.r_ps;
				best_pe_d     = item.r_pe;
				best_proto_d  = item.r_proto;
				best_diff_d   = item.r_diff;
			end else begin
				best_s_d      = '0;
				best_e_d      = '0;
				best_ps_d     = '0;
				best_pe_d     = '0;
				best_proto_d  = '0;
				best_diff_d   = '0;
			end
		end else if (cand) begin
			no_extra_d = 1'b0;
			if (better) begin
				if (!no_extra_q)
					narrowed_d = 1'b1;
				best_s_d      = item.r_s;
				best_e_d      = item.n_e;
				best_ps_d     = item.n_ps;
				best_pe_d     = item.n_pe;
				best_proto_d  = item.r_proto;
				best_diff_d   = item.n_diff;
			end
		end
		if (item.last)
			open_d = 1'b0;
	end

	assign sel_s = best_s_d & om;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q        <= 1'b0;
			no_extra_q    <= 1'b1;
			failed_q      <= 1'b0;
			narrowed_q    <= 1'b0;
			first_s_q     <= '0;
			first_e_q     <= '0;
			first_ps_q    <= '0;
			first_pe_q    <= '0;
			chosen_q      <= '0;
			best_s_q      <= '0;
			best_e_q      <= '0;
			best_ps_q     <= '0;
			best_pe_q     <= '0;
			best_proto_q  <= '0;
			best_diff_q   <= '0;
			out_valid     <= 1'b0;
		end else begin
			if (pop && item.last)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			if (pop) begin
				open_q        <= open_d;
				no_extra_q    <= no_extra_d;
				failed_q      <= failed_d;
				narrowed_q    <= narrowed_d;
				first_s_q     <= first_s_d;
				first_e_q     <= first_e_d;
				first_ps_q    <= first_ps_d;
				first_pe_q    <= first_pe_d;
				chosen_q      <= chosen_d;
				best_s_q      <= best_s_d;
				best_e_q      <= best_e_d;
				best_ps_q     <= best_ps_d;
				best_pe_q     <= best_pe_d;
				best_proto_q  <= best_proto_d;
				best_diff_q   <= best_diff_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.last) begin
			if (failed_d) begin
				sel_addr_hi <= '0;
				sel_addr_lo <= '0;
				sel_prefix  <= '0;
				sel_port    <= '0;
				sel_proto   <= '0;
				accepted    <= 1'b0;
				narrowed    <= 1'b0;
			end else begin
				sel_addr_hi <= sel_s[127:64];
				sel_addr_lo <= sel_s[63:0];
				sel_prefix  <= replace ? item.prefix : held_prefix;
				sel_port    <= single_port(best_ps_d, best_pe_d);
				sel_proto   <= best_proto_d;
				accepted    <= 1'b1;
				narrowed    <= narrowed_d;
			end
		end
	end

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accepted) |-> (sel_addr_hi == 64'd0 && sel_addr_lo == 64'd0 &&
		sel_port == 16'd0 && !narrowed)) else $error("failed payload not cleared");
	a_prefix_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sel_prefix <= WIDTH_V6) else $error("prefix out of range");
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && item.last) |=> !open_q) else $error("payload left open");

endmodule
`default_nettype wire
